>>> sv/spmq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority message queue package
// Shared sizes, codes, state type and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package spmq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} state_t;

	typedef struct packed {
		logic    insert;
		logic    remove;
		logic    load;
		status_t load_status;
	} dp_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/spmq_if.sv
// ----------------------------------------------------------------------------
// Stable priority message queue channels
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface spmq_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic        [31:0] msg_name;
	logic signed [31:0] msg_param;
	logic        [15:0] msg_priority;

	modport source (output valid, output command, output msg_name, output msg_param,
		output msg_priority, input ready);
	modport sink (input valid, input command, input msg_name, input msg_param,
		input msg_priority, output ready);
endinterface

interface spmq_out_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic        [31:0] out_name;
	logic signed [31:0] out_param;

	modport source (output valid, output status, output out_name, output out_param,
		input ready);
	modport sink (input valid, input status, input out_name, input out_param,
		output ready);
endinterface

`default_nettype wire

>>> sv/spmq_ctrl.sv
// ----------------------------------------------------------------------------
// Stable priority message queue controller
// Accepts requests, issues insert/remove/load commands and waits until results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spmq_ctrl
	import spmq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_command,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_ctrl_t      ctrl
);

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   is_put;

	assign accept = in_valid && in_ready;
	assign is_put = (in_command == CMD_PUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !(is_put && !stat.full)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == S_IDLE);
		out_valid        = (state_q == S_RESP);
		ctrl.insert      = accept && is_put && !stat.full;
		ctrl.remove      = accept && !is_put && !stat.empty;
		ctrl.load        = accept && !(is_put && !stat.full);
		if (is_put) begin
			ctrl.load_status = ST_FULL;
		end else if (stat.empty) begin
			ctrl.load_status = ST_EMPTY;
		end else begin
			ctrl.load_status = ST_OK;
		end
	end

endmodule

`default_nettype wire

>>> sv/spmq_datapath.sv
// ----------------------------------------------------------------------------
// Stable priority message queue datapath
// Sorted shifting cell array with fill count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spmq_datapath
	import spmq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_ctrl_t           ctrl,
	input  wire logic        [31:0] in_name,
	input  wire logic signed [31:0] in_param,
	input  wire logic        [15:0] in_priority,
	output dp_stat_t                stat,
	output logic             [1:0]  res_status,
	output logic             [31:0] res_name,
	output logic signed      [31:0] res_param
);

	logic        [31:0] name_q  [CAPACITY];
	logic signed [31:0] param_q [CAPACITY];
	logic        [15:0] prio_q  [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [CAPACITY-1:0] le;

	logic [1:0]         status_q;
	logic        [31:0] out_name_q;
	logic signed [31:0] out_param_q;

	assign stat.full  = (count_q == CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		// Cells holding an entry that stays ahead of the new message.
		assign le[gi] = (CNT_W'(gi) < count_q) && (prio_q[gi] <= in_priority);

		always_ff @(posedge clk) begin
			if (ctrl.insert && !le[gi]) begin
				if (gi == 0) begin
					name_q[gi]  <= in_name;
					param_q[gi] <= in_param;
					prio_q[gi]  <= in_priority;
				end else if (le[(gi > 0) ? gi - 1 : 0]) begin
					name_q[gi]  <= in_name;
					param_q[gi] <= in_param;
					prio_q[gi]  <= in_priority;
				end else begin
					name_q[gi]  <= name_q[(gi > 0) ? gi - 1 : 0];
					param_q[gi] <= param_q[(gi > 0) ? gi - 1 : 0];
					prio_q[gi]  <= prio_q[(gi > 0) ? gi - 1 : 0];
				end
			end else if (ctrl.remove && (gi < CAPACITY - 1)) begin
				name_q[gi]  <= name_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
				param_q[gi] <= param_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
				prio_q[gi]  <= prio_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.remove) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			status_q <= ctrl.load_status;
			if (ctrl.load_status == ST_OK) begin
				out_name_q  <= name_q[0];
				out_param_q <= param_q[0];
			end else begin
				out_name_q  <= '0;
				out_param_q <= '0;
			end
		end
	end

	assign res_status = status_q;
	assign res_name   = out_name_q;
	assign res_param  = out_param_q;

endmodule

`default_nettype wire

>>> sv/stable_priority_message_queue_top.sv
// ----------------------------------------------------------------------------
// Stable priority message queue top level
// Bounded priority queue with first-in first-out order among equal priorities.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  in_ch    | in  | command, msg_name, msg_param, msg_priority
//  out_ch   | out | status, out_name, out_param
//
//  A request is taken in the cycle that valid and ready are both high; the cell array inserts or removes at once.
//  A successful PUT gives no result and the next request is taken the next cycle.
//  Any other request loads the result register; new requests wait until it is taken.
//  Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_message_queue_top
	import spmq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	spmq_in_if.sink   in_ch,
	spmq_out_if.source out_ch
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	spmq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	spmq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_name     (in_ch.msg_name),
		.in_param    (in_ch.msg_param),
		.in_priority (in_ch.msg_priority),
		.stat        (stat),
		.res_status  (out_ch.status),
		.res_name    (out_ch.out_name),
		.res_param   (out_ch.out_param)
	);

`ifndef SYNTH
	a_put_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.command == CMD_PUT && !stat.full
		|=> !out_ch.valid)
		else $error("successful put produced a result");

	a_get_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.command == CMD_GET |=> out_ch.valid)
		else $error("get produced no result");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.command == CMD_GET && stat.empty
		|=> out_ch.status == ST_EMPTY)
		else $error("get on empty queue not reported");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue both full and empty");
`endif

endmodule

`default_nettype wire
